>>> hdl/alt_pkg.sv
// Shared types and codes for the access list table.
package alt_pkg;

	localparam int unsigned RIGHTS = 8;
	localparam int unsigned KEY_BITS = 64;
	localparam int unsigned RIGHT_BITS = 4;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] K_APPEND = 2'd0;
	localparam logic [1:0] K_CHECK = 2'd1;
	localparam logic [1:0] K_DELETE = 2'd2;
	localparam logic [1:0] K_INVALID = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [RIGHT_BITS-1:0] right;
		logic [KEY_BITS-1:0] key;
	} cmd_t;

endpackage

>>> hdl/alt_req_if.sv
// Request channel: operation, right index and key.
interface alt_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [3:0] right_index;
	logic [63:0] auth_key;

	modport source(output valid, output operation, output right_index, output auth_key,
		input ready);
	modport sink(input valid, input operation, input right_index, input auth_key,
		output ready);
endinterface

>>> hdl/alt_rsp_if.sv
// Response channel: status word.
interface alt_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;

	modport source(output valid, output status, input ready);
	modport sink(input valid, input status, output ready);
endinterface

>>> hdl/alt_ram.sv
// Generic single write port, single read port RAM with registered read.
module alt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> hdl/alt_front.sv
// Front end: accepts request words, classifies them and queues commands.
module alt_front #(
	parameter int unsigned AD_BYTES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	alt_req_if.sink       req,
	input  logic          clearing,
	output alt_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_ready
);
	import alt_pkg::*;

	localparam int unsigned KEY_W = 8 * AD_BYTES;
	localparam logic [KEY_BITS-1:0] KEY_MASK = {KEY_BITS{1'b1}} >> (KEY_BITS - KEY_W);

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       new_cmd;
	logic       push;
	logic       pop;

	always_comb begin
		new_cmd.right = req.right_index;
		new_cmd.key = req.auth_key & KEY_MASK;
		if ({1'b0, req.right_index} >= 5'(RIGHTS)) begin
			new_cmd.kind = K_INVALID;
		end else begin
			case (req.operation)
				OP_APPEND: new_cmd.kind = K_APPEND;
				OP_CHECK:  new_cmd.kind = K_CHECK;
				OP_DELETE: new_cmd.kind = K_DELETE;
				default:   new_cmd.kind = K_INVALID;
			endcase
		end
	end

	assign req.ready = (count_q != 2'd2) && !clearing;
	assign push = req.valid && req.ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("command queue count out of range");
	a_no_push_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push) else $error("request taken during clearing pass");
endmodule

>>> hdl/alt_back.sv
// Back end: clears the table, walks the entries and returns the status.
module alt_back #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned AD_BYTES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  alt_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output logic          clearing,
	alt_rsp_if.source     rsp
);
	import alt_pkg::*;

	localparam int unsigned KEY_W = 8 * AD_BYTES;
	localparam int unsigned EW = 1 + RIGHT_BITS + KEY_W;
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0]    state_q;
	cmd_t          cur_q;
	logic [AW-1:0] cnt_q;
	logic          issue_q;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;
	logic [1:0]    stat_q;
	logic          ovalid_q;
	logic [1:0]    ostat_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [EW-1:0] ram_rdata;
	logic          slot_vld;
	logic          slot_match;
	logic          scan_hit;
	logic          scan_end;
	logic          load_out;

	alt_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	assign clearing = (state_q == S_CLEAR);
	assign cmd_ready = (state_q == S_IDLE);

	assign slot_vld = ram_rdata[EW-1];
	assign slot_match = slot_vld && (ram_rdata[EW-2 -: RIGHT_BITS] == cur_q.right)
		&& (ram_rdata[KEY_W-1:0] == cur_q.key[KEY_W-1:0]);
	assign scan_hit = pend_s1 && ((cur_q.kind == K_APPEND) ? !slot_vld : slot_match);
	assign scan_end = pend_s1 && (addr_s1 == LAST);

	assign ram_re = (state_q == S_SCAN) && issue_q;
	assign ram_we = clearing || ((state_q == S_SCAN) && scan_hit && (cur_q.kind != K_CHECK));
	assign ram_waddr = clearing ? cnt_q : addr_s1;
	assign ram_wdata = (!clearing && (cur_q.kind == K_APPEND))
		? {1'b1, cur_q.right, cur_q.key[KEY_W-1:0]} : '0;

	assign load_out = (state_q == S_OUT) && (!ovalid_q || rsp.ready);
	assign rsp.valid = ovalid_q;
	assign rsp.status = ostat_q;

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cur_q <= cmd;
		end
		if (load_out) begin
			ostat_q <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			addr_s1 <= '0;
			stat_q <= ST_OK;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == K_INVALID) begin
							stat_q <= ST_INVALID;
							state_q <= S_OUT;
						end else begin
							cnt_q <= '0;
							issue_q <= 1'b1;
							pend_s1 <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit || scan_end) begin
						if (scan_hit) begin
							stat_q <= ST_OK;
						end else begin
							stat_q <= (cur_q.kind == K_APPEND) ? ST_FULL : ST_NOT_FOUND;
						end
						issue_q <= 1'b0;
						pend_s1 <= 1'b0;
						state_q <= S_OUT;
					end else begin
						pend_s1 <= issue_q;
						addr_s1 <= cnt_q;
						if (issue_q) begin
							if (cnt_q == LAST) begin
								issue_q <= 1'b0;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_check_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clearing) |-> (cur_q.kind != K_CHECK))
		else $error("table written by a check");
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_SCAN)) else $error("read pending outside scan");
	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && scan_hit) |=> (state_q == S_OUT))
		else $error("scan did not stop on hit");
endmodule

>>> hdl/access_list_table_core.sv
// Top level of the access list table.
//
// Requests arrive on req (operation, right_index, auth_key); one status word
// leaves on rsp for every request, in order. Both channels move a word when
// valid and ready are high at a rising clock edge.
// Append stores the pair in the lowest free slot (table full when none),
// check reports whether a matching pair exists, delete invalidates the
// lowest matching slot (not found when none). A right index at or above the
// right count, or the reserved operation, returns invalid with no change.
// A front end classifies requests into a two-deep command queue; the back
// end walks the table RAM one entry a cycle through its single read port.
// The back end takes the next command the cycle after the status word is
// registered, so it handles one request at a time. After reset the back
// end clears every table entry, during which req.ready stays low. A
// stalled rsp holds the status word; the back end finishes one more
// request and holds it, and the queue takes two more.
module access_list_table_core #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned AD_BYTES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	alt_req_if.sink   req,
	alt_rsp_if.source rsp
);
	import alt_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;
	logic clearing;

	alt_front #(.AD_BYTES(AD_BYTES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.clearing(clearing),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready)
	);

	alt_back #(.ENTRIES(ENTRIES), .AD_BYTES(AD_BYTES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.clearing(clearing),
		.rsp(rsp)
	);
endmodule

>>> dv/access_list_table_checker.sv
// Checker for the access list table: tracks the stored grants and compares every status word.
module access_list_table_checker #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned AD_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	alt_req_if          req,
	alt_rsp_if          rsp,
	output int unsigned mismatches,
	output int unsigned statuses_checked,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import alt_pkg::*;

	localparam logic [KEY_BITS-1:0] KEY_MASK = (AD_BYTES >= 8) ? '1 :
		((64'd1 << (8 * AD_BYTES)) - 64'd1);
	localparam int unsigned MAX_PRINTED = 20;

	typedef struct {
		logic [1:0]            op;
		logic [RIGHT_BITS-1:0] right;
		logic [KEY_BITS-1:0]   key;
		logic [1:0]            status;
	} status_due_t;

	logic                  slot_used [ENTRIES];
	logic [RIGHT_BITS-1:0] slot_right [ENTRIES];
	logic [KEY_BITS-1:0]   slot_key [ENTRIES];
	status_due_t           status_due [$];

	function automatic logic [1:0] table_status(logic [1:0] op, logic [RIGHT_BITS-1:0] right,
		logic [KEY_BITS-1:0] key_in);
		logic [KEY_BITS-1:0] key;
		int hit;
		int hole;
		key = key_in & KEY_MASK;
		hit = -1;
		hole = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!slot_used[i]) begin
				hole = i;
			end else if (slot_right[i] == right && slot_key[i] == key) begin
				hit = i;
			end
		end
		if (right >= RIGHTS) begin
			return ST_INVALID;
		end
		case (op)
			OP_APPEND: begin
				if (hole < 0) begin
					return ST_FULL;
				end
				slot_used[hole] = 1'b1;
				slot_right[hole] = right;
				slot_key[hole] = key;
				return ST_OK;
			end
			OP_CHECK: begin
				return (hit >= 0) ? ST_OK : ST_NOT_FOUND;
			end
			OP_DELETE: begin
				if (hit < 0) begin
					return ST_NOT_FOUND;
				end
				slot_used[hit] = 1'b0;
				return ST_OK;
			end
			default: begin
				return ST_INVALID;
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("%0t: mismatch: %s", $time, what);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_due_t due;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
			end
			status_due.delete();
			mismatches = 0;
			statuses_checked = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (status_due.size() == 0) begin
					report_mismatch($sformatf("status %0d with no request outstanding",
						rsp.status));
				end else begin
					due = status_due.pop_front();
					statuses_checked++;
					if (rsp.status !== due.status) begin
						report_mismatch($sformatf(
							"op %0d right %0d key %h: status %0d, expected %0d",
							due.op, due.right, due.key, rsp.status, due.status));
					end
				end
			end
			if (req.valid && req.ready) begin
				due.op = req.operation;
				due.right = req.right_index;
				due.key = req.auth_key;
				due.status = table_status(req.operation, req.right_index, req.auth_key);
				status_due.push_back(due);
			end
			pending = status_due.size();
		end
	end

endmodule

>>> dv/access_list_table_core_test.sv
// Testbench top for the access list table: clock, reset, request stimulus and verdict.
module access_list_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import alt_pkg::*;

	localparam int unsigned TABLE_SLOTS = 64;
	localparam int unsigned ITEMS = 1650;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned TAIL_CYCLES = 100;
	localparam logic [KEY_BITS-1:0] DUP_KEY = 64'hA5A5_5A5A_F00F_0FF0;

	typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_e;

	typedef struct packed {
		logic [RIGHT_BITS-1:0] right;
		logic [KEY_BITS-1:0]   key;
	} grant_t;

	logic clk;
	logic arst_n;
	int unsigned mismatches;
	int unsigned statuses_checked;
	int unsigned pending;
	int unsigned words_sent;
	int unsigned sent_by_op [4];
	int unsigned burst_left;

	alt_req_if req ();
	alt_rsp_if rsp ();

	access_list_table_core #(
		.ENTRIES(TABLE_SLOTS),
		.AD_BYTES(8)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	access_list_table_checker #(
		.ENTRIES(TABLE_SLOTS),
		.AD_BYTES(8)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.mismatches(mismatches),
		.statuses_checked(statuses_checked),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [KEY_BITS-1:0] fresh_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// hold the word until taken; when the burst ends, start a new one, often after a random gap
	task automatic send_word(logic [1:0] op, logic [RIGHT_BITS-1:0] right,
		logic [KEY_BITS-1:0] key);
		int unsigned gap;
		req.valid <= 1'b1;
		req.operation <= op;
		req.right_index <= right;
		req.auth_key <= key;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		words_sent++;
		sent_by_op[op]++;
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
				$urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin : receiver
		int unsigned mode;
		int unsigned mode_left;
		mode = 0;
		mode_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 1) == 0);
				2: rsp.ready <= ($urandom_range(0, 9) != 0);
				default: rsp.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("No word moved for %0d cycles, %0d status words outstanding",
			QUIET_LIMIT, pending);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		grant_t held [$];
		grant_t g;
		phase_e phase;
		logic [1:0] valid_ops [3];
		logic [1:0] op;
		logic [RIGHT_BITS-1:0] r;
		logic [KEY_BITS-1:0] k;
		int unsigned len;
		int unsigned roll;
		int unsigned append_share;
		int unsigned check_share;
		int unsigned idx;
		bit first_phase;

		valid_ops = '{OP_APPEND, OP_CHECK, OP_DELETE};
		req.valid <= 1'b0;
		req.operation <= OP_APPEND;
		req.right_index <= '0;
		req.auth_key <= '0;
		arst_n <= 1'b0;
		words_sent = 0;
		burst_left = 0;
		first_phase = 1'b1;
		foreach (sent_by_op[i]) sent_by_op[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_word(OP_CHECK, 4'd0, '0);
		send_word(OP_DELETE, 4'd0, '0);
		send_word(OP_APPEND, 4'd0, '0);
		send_word(OP_APPEND, RIGHT_BITS'(RIGHTS - 1), '1);
		send_word(OP_CHECK, 4'd0, '0);
		send_word(OP_CHECK, RIGHT_BITS'(RIGHTS - 1), '1);
		send_word(OP_CHECK, RIGHT_BITS'(RIGHTS - 1), '0);
		send_word(OP_CHECK, 4'd0, '1);
		send_word(OP_APPEND, RIGHT_BITS'(RIGHTS), DUP_KEY);
		send_word(OP_CHECK, 4'd15, '1);
		send_word(OP_DELETE, 4'd15, '0);
		send_word(K_INVALID, 4'd0, '0);
		send_word(K_INVALID, 4'd15, '1);
		send_word(OP_APPEND, 4'd3, DUP_KEY);
		send_word(OP_APPEND, 4'd3, DUP_KEY);
		send_word(OP_DELETE, 4'd3, DUP_KEY);
		send_word(OP_CHECK, 4'd3, DUP_KEY);
		send_word(OP_DELETE, 4'd3, DUP_KEY);
		send_word(OP_CHECK, 4'd3, DUP_KEY);
		send_word(OP_DELETE, 4'd3, DUP_KEY);
		send_word(OP_DELETE, 4'd0, '0);
		send_word(OP_DELETE, RIGHT_BITS'(RIGHTS - 1), '1);

		while (words_sent < ITEMS) begin
			phase = first_phase ? PHASE_FILL : phase_e'($urandom_range(0, 2));
			len = first_phase ? 150 : $urandom_range(30, 140);
			first_phase = 1'b0;
			case (phase)
				PHASE_FILL: begin
					append_share = 75;
					check_share = 90;
				end
				PHASE_DRAIN: begin
					append_share = 15;
					check_share = 35;
				end
				default: begin
					append_share = 35;
					check_share = 70;
				end
			endcase
			repeat (len) begin
				roll = $urandom_range(0, 99);
				r = RIGHT_BITS'($urandom_range(0, RIGHTS - 1));
				k = fresh_key();
				if (roll < 3) begin
					op = K_INVALID;
					r = RIGHT_BITS'($urandom_range(0, 15));
				end else if (roll < 6) begin
					op = valid_ops[$urandom_range(0, 2)];
					r = RIGHT_BITS'($urandom_range(RIGHTS, 15));
				end else begin
					roll = $urandom_range(0, 99);
					op = (roll < append_share) ? OP_APPEND :
						(roll < check_share) ? OP_CHECK : OP_DELETE;
					roll = $urandom_range(0, 99);
					case (op)
						OP_APPEND: begin
							if (held.size() > 0 && roll < 20) begin
								g = held[$urandom_range(0, held.size() - 1)];
								r = g.right;
								k = g.key;
							end
							if (held.size() < TABLE_SLOTS) begin
								g.right = r;
								g.key = k;
								held.push_back(g);
							end
						end
						OP_CHECK: begin
							if (held.size() > 0 && roll < 60) begin
								g = held[$urandom_range(0, held.size() - 1)];
								r = g.right;
								k = g.key;
								if ($urandom_range(0, 6) == 0) begin
									k ^= 64'd1 << $urandom_range(0, 63);
								end
							end
						end
						default: begin
							if (held.size() > 0 && roll < 75) begin
								idx = $urandom_range(0, held.size() - 1);
								g = held[idx];
								held.delete(idx);
								r = g.right;
								k = g.key;
							end
						end
					endcase
				end
				send_word(op, r, k);
			end
		end

		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d requests: %0d append, %0d check, %0d delete, %0d reserved",
			words_sent, sent_by_op[OP_APPEND], sent_by_op[OP_CHECK],
			sent_by_op[OP_DELETE], sent_by_op[K_INVALID]);
		$display("Compared %0d status words across fill, drain and mixed phases, %0d wrong",
			statuses_checked, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
